### rtl/core/abtd_pkg.sv
// ---------------------------------------------------------------------------
// abtd_pkg
// Shared types, register codes and helpers of the adaptive threshold beat
// detector.
// ---------------------------------------------------------------------------
package abtd_pkg;

	// Register map, word index on the configuration port.
	typedef enum logic [2:0] {
		RI_COEF_B0        = 3'd0,
		RI_COEF_B2        = 3'd1,
		RI_COEF_A1        = 3'd2,
		RI_COEF_A2        = 3'd3,
		RI_STATS_RATE     = 3'd4,
		RI_THRESH_GAIN    = 3'd5,
		RI_HOLDOFF_MS     = 3'd6
	} reg_idx_t;

	localparam logic [15:0] RST_COEF_B0       = 16'd2941;
	localparam logic [15:0] RST_COEF_B2       = 16'hF483;
	localparam logic [15:0] RST_COEF_A1       = 16'h98A2;
	localparam logic [15:0] RST_COEF_A2       = 16'd10500;
	localparam logic [15:0] RST_STATS_RATE    = 16'd655;
	localparam logic [15:0] RST_THRESH_GAIN   = 16'd2048;
	localparam logic [15:0] RST_HOLDOFF_MS    = 16'd280;

	localparam logic [47:0] RST_VARIANCE = 48'd65536;

	typedef struct packed {
		logic [15:0] coef_b0;
		logic [15:0] coef_b2;
		logic [15:0] coef_a1;
		logic [15:0] coef_a2;
		logic [15:0] stats_rate;
		logic [15:0] thresh_gain;
		logic [15:0] holdoff_ms;
	} cfg_t;

	// Sequencer of the arithmetic back end.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MB0,
		ST_Y,
		ST_MA1,
		ST_N1,
		ST_B2X,
		ST_N2,
		ST_MEAN,
		ST_SQ,
		ST_VSUM,
		ST_VMUL,
		ST_VAR,
		ST_SQRT,
		ST_GAIN,
		ST_THR
	} seq_state_t;

	function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
		logic signed [31:0] r;
		if (v > 50'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -50'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

### rtl/core/adaptive_threshold_beat_detector_core.sv
// ---------------------------------------------------------------------------
// adaptive_threshold_beat_detector_core
// Band-pass filters pulse-sensor samples, tracks running mean and variance,
// and flags beats above an adaptive threshold.
// ---------------------------------------------------------------------------
//  channel  | signals                                 | direction
//  ---------+-----------------------------------------+----------
//  input    | in_valid, in_stall, sample, now_ms      | into core
//  result   | out_valid, out_stall, beat, armed_high, | out of core
//           | filtered, threshold                     |
//  config   | psel, penable, pwrite, paddr, pwdata,   | into core
//           | prdata, pready                          |
//
// Each word passes through the sequencer steps of the back end, around two
// shared multipliers and a one-bit-per-cycle square root.
// A two-entry queue takes up to two words while the back end is busy.
// The result register holds one word; the back end waits while it is stalled.
// Reset restores register and variance defaults, clears filter and mean.
// ---------------------------------------------------------------------------
module adaptive_threshold_beat_detector_core #(
	parameter int SAMPLE_BITS = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic [31:0]            now_ms,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   beat,
	output logic                   armed_high,
	output logic signed [31:0]     filtered,
	output logic signed [31:0]     threshold,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [4:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	abtd_pkg::cfg_t                cfg;
	logic                          q_valid;
	logic                          q_pop;
	logic signed [SAMPLE_BITS-1:0] q_x;
	logic [31:0]                   q_now;

	abtd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	abtd_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sample   (sample),
		.now_ms   (now_ms),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_x      (q_x),
		.q_now    (q_now)
	);

	abtd_back #(.SAMPLE_BITS(SAMPLE_BITS)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.q_valid       (q_valid),
		.q_pop         (q_pop),
		.q_x           (q_x),
		.q_now         (q_now),
		.res_valid     (out_valid),
		.res_stall     (out_stall),
		.res_beat      (beat),
		.res_armed     (armed_high),
		.res_filtered  (filtered),
		.res_threshold (threshold)
	);

endmodule

### rtl/core/abtd_regs.sv
// ---------------------------------------------------------------------------
// abtd_regs
// Configuration register file behind a simple APB-style slave port.
// ---------------------------------------------------------------------------
module abtd_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [4:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output abtd_pkg::cfg_t      cfg
);

	abtd_pkg::cfg_t    cfg_q;
	abtd_pkg::reg_idx_t idx;
	logic              wr_en;

	assign idx    = abtd_pkg::reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.coef_b0       <= abtd_pkg::RST_COEF_B0;
			cfg_q.coef_b2       <= abtd_pkg::RST_COEF_B2;
			cfg_q.coef_a1       <= abtd_pkg::RST_COEF_A1;
			cfg_q.coef_a2       <= abtd_pkg::RST_COEF_A2;
			cfg_q.stats_rate    <= abtd_pkg::RST_STATS_RATE;
			cfg_q.thresh_gain   <= abtd_pkg::RST_THRESH_GAIN;
			cfg_q.holdoff_ms    <= abtd_pkg::RST_HOLDOFF_MS;
		end else if (wr_en) begin
			case (idx)
				abtd_pkg::RI_COEF_B0:       cfg_q.coef_b0       <= pwdata[15:0];
				abtd_pkg::RI_COEF_B2:       cfg_q.coef_b2       <= pwdata[15:0];
				abtd_pkg::RI_COEF_A1:       cfg_q.coef_a1       <= pwdata[15:0];
				abtd_pkg::RI_COEF_A2:       cfg_q.coef_a2       <= pwdata[15:0];
				abtd_pkg::RI_STATS_RATE:    cfg_q.stats_rate    <= pwdata[15:0];
				abtd_pkg::RI_THRESH_GAIN:   cfg_q.thresh_gain   <= pwdata[15:0];
				abtd_pkg::RI_HOLDOFF_MS:    cfg_q.holdoff_ms    <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			abtd_pkg::RI_COEF_B0:       prdata = {16'h0, cfg_q.coef_b0};
			abtd_pkg::RI_COEF_B2:       prdata = {16'h0, cfg_q.coef_b2};
			abtd_pkg::RI_COEF_A1:       prdata = {16'h0, cfg_q.coef_a1};
			abtd_pkg::RI_COEF_A2:       prdata = {16'h0, cfg_q.coef_a2};
			abtd_pkg::RI_STATS_RATE:    prdata = {16'h0, cfg_q.stats_rate};
			abtd_pkg::RI_THRESH_GAIN:   prdata = {16'h0, cfg_q.thresh_gain};
			abtd_pkg::RI_HOLDOFF_MS:    prdata = {16'h0, cfg_q.holdoff_ms};
			default:                    prdata = 32'h0;
		endcase
	end

endmodule

### rtl/core/abtd_front.sv
// ---------------------------------------------------------------------------
// abtd_front
// Input side: takes words, centers the sample and holds them in a
// two-entry queue for the arithmetic back end.
// ---------------------------------------------------------------------------
module abtd_front #(
	parameter int SAMPLE_BITS = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [SAMPLE_BITS-1:0]        sample,
	input  logic [31:0]                   now_ms,
	output logic                          q_valid,
	input  logic                          q_pop,
	output logic signed [SAMPLE_BITS-1:0] q_x,
	output logic [31:0]                   q_now
);

	logic signed [SAMPLE_BITS-1:0] x_mem [2];
	logic [31:0]                   now_mem [2];
	logic [1:0]                    count_q;
	logic                          wr_ptr_q;
	logic                          rd_ptr_q;
	logic                          push;
	logic                          pop;

	assign in_stall = (count_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (count_q != 2'd0);
	assign pop      = q_pop && q_valid;
	assign q_x      = x_mem[rd_ptr_q];
	assign q_now    = now_mem[rd_ptr_q];

	// Subtracting half scale from offset binary is an inversion of the top bit.
	always_ff @(posedge clk) begin
		if (push) begin
			x_mem[wr_ptr_q]   <= {~sample[SAMPLE_BITS-1], sample[SAMPLE_BITS-2:0]};
			now_mem[wr_ptr_q] <= now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("queue count out of range");

	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> (count_q == $past(count_q) - 2'd1))
		else $error("queue pop did not drain an entry");

	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd2 && !q_pop) |=> (count_q == 2'd2))
		else $error("full queue lost an entry");

endmodule

### rtl/core/abtd_back.sv
// ---------------------------------------------------------------------------
// abtd_back
// Arithmetic back end: a sequencer around two registered multipliers and a
// one-bit-per-cycle square root, with the result register at its output.
// ---------------------------------------------------------------------------
module abtd_back #(
	parameter int SAMPLE_BITS = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  abtd_pkg::cfg_t                cfg,
	input  logic                          q_valid,
	output logic                          q_pop,
	input  logic signed [SAMPLE_BITS-1:0] q_x,
	input  logic [31:0]                   q_now,
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic                          res_beat,
	output logic                          res_armed,
	output logic signed [31:0]            res_filtered,
	output logic signed [31:0]            res_threshold
);

	abtd_pkg::seq_state_t state_q;
	abtd_pkg::seq_state_t state_d;

	logic signed [SAMPLE_BITS-1:0] x_q;
	logic [31:0]        now_q;
	logic signed [31:0] y_q;
	logic signed [32:0] d_q;
	logic [31:0]        mag_q;
	logic signed [33:0] t_q;
	logic [47:0]        sum_q;
	logic [63:0]        rad_q;
	logic [33:0]        rem_q;
	logic [31:0]        root_q;
	logic [4:0]         cnt_q;
	logic signed [67:0] pa_q;
	logic [64:0]        pb_q;

	logic signed [31:0] d1_q;
	logic signed [31:0] d2_q;
	logic signed [31:0] mean_q;
	logic [47:0]        var_q;
	logic               above_q;
	logic [31:0]        last_q;

	logic               res_valid_q;
	logic               res_beat_q;
	logic               res_armed_q;
	logic signed [31:0] res_filtered_q;
	logic signed [31:0] res_threshold_q;

	logic signed [33:0] ma_a;
	logic signed [33:0] ma_b;
	logic [47:0]        mb_a;
	logic [16:0]        mb_b;

	logic               out_free;
	logic               out_load;
	logic               take;
	logic               sqrt_last;

	logic signed [49:0] y_sum;
	logic signed [49:0] n1_sum;
	logic signed [49:0] n2_sum;
	logic signed [49:0] mean_sum;
	logic signed [49:0] thr_sum;
	logic signed [31:0] thr;
	logic [32:0]        abs_d;
	logic [48:0]        var_sum;
	logic [35:0]        sq_shift;
	logic [35:0]        sq_trial;
	logic [35:0]        sq_diff;
	logic               sq_ge;
	logic [31:0]        elapsed;
	logic               beat;
	logic               above_set;
	logic               above_next;

	assign out_free  = !res_valid_q || !res_stall;
	assign sqrt_last = (cnt_q == 5'd31);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			abtd_pkg::ST_IDLE: if (q_valid) state_d = abtd_pkg::ST_MB0;
			abtd_pkg::ST_MB0:  state_d = abtd_pkg::ST_Y;
			abtd_pkg::ST_Y:    state_d = abtd_pkg::ST_MA1;
			abtd_pkg::ST_MA1:  state_d = abtd_pkg::ST_N1;
			abtd_pkg::ST_N1:   state_d = abtd_pkg::ST_B2X;
			abtd_pkg::ST_B2X:  state_d = abtd_pkg::ST_N2;
			abtd_pkg::ST_N2:   state_d = abtd_pkg::ST_MEAN;
			abtd_pkg::ST_MEAN: state_d = abtd_pkg::ST_SQ;
			abtd_pkg::ST_SQ:   state_d = abtd_pkg::ST_VSUM;
			abtd_pkg::ST_VSUM: state_d = abtd_pkg::ST_VMUL;
			abtd_pkg::ST_VMUL: state_d = abtd_pkg::ST_VAR;
			abtd_pkg::ST_VAR:  state_d = abtd_pkg::ST_SQRT;
			abtd_pkg::ST_SQRT: if (sqrt_last) state_d = abtd_pkg::ST_GAIN;
			abtd_pkg::ST_GAIN: state_d = abtd_pkg::ST_THR;
			abtd_pkg::ST_THR:  if (out_free) state_d = abtd_pkg::ST_IDLE;
			default:           state_d = abtd_pkg::ST_IDLE;
		endcase
	end

	// Control outputs and multiplier operand selection.
	always_comb begin
		q_pop    = 1'b0;
		out_load = 1'b0;
		ma_a     = '0;
		ma_b     = '0;
		mb_a     = '0;
		mb_b     = '0;
		case (state_q)
			abtd_pkg::ST_IDLE: q_pop = q_valid;
			abtd_pkg::ST_MB0: begin
				ma_a = {{18{cfg.coef_b0[15]}}, cfg.coef_b0};
				ma_b = {{(34-SAMPLE_BITS){x_q[SAMPLE_BITS-1]}}, x_q};
			end
			abtd_pkg::ST_MA1: begin
				ma_a = {{18{cfg.coef_a1[15]}}, cfg.coef_a1};
				ma_b = {{2{y_q[31]}}, y_q};
			end
			abtd_pkg::ST_N1: begin
				ma_a = {{18{cfg.coef_b2[15]}}, cfg.coef_b2};
				ma_b = {{(34-SAMPLE_BITS){x_q[SAMPLE_BITS-1]}}, x_q};
			end
			abtd_pkg::ST_B2X: begin
				ma_a = {{18{cfg.coef_a2[15]}}, cfg.coef_a2};
				ma_b = {{2{y_q[31]}}, y_q};
			end
			abtd_pkg::ST_N2: begin
				ma_a = {18'h0, cfg.stats_rate};
				ma_b = {d_q[32], d_q};
			end
			abtd_pkg::ST_MEAN: begin
				ma_a = {2'b00, mag_q};
				ma_b = {2'b00, mag_q};
			end
			abtd_pkg::ST_SQ: begin
				mb_a = pa_q[63:16];
				mb_b = {1'b0, cfg.stats_rate};
			end
			abtd_pkg::ST_VMUL: begin
				mb_a = sum_q;
				mb_b = 17'h10000 - {1'b0, cfg.stats_rate};
			end
			abtd_pkg::ST_GAIN: begin
				ma_a = {18'h0, cfg.thresh_gain};
				ma_b = {2'b00, root_q};
			end
			abtd_pkg::ST_THR: begin
				// The gain product is kept in the multiplier while the result waits.
				ma_a     = {18'h0, cfg.thresh_gain};
				ma_b     = {2'b00, root_q};
				out_load = out_free;
			end
			default: ;
		endcase
	end

	assign take = q_pop;

	// Datapath arithmetic per step.
	always_comb begin
		y_sum    = {pa_q[47:0], 2'b00} + {{18{d1_q[31]}}, d1_q};
		n1_sum   = {{18{d2_q[31]}}, d2_q} - {{14{pa_q[49]}}, pa_q[49:14]};
		n2_sum   = {{16{t_q[33]}}, t_q} - {{14{pa_q[49]}}, pa_q[49:14]};
		mean_sum = {{18{mean_q[31]}}, mean_q} + {{16{pa_q[49]}}, pa_q[49:16]};
		thr_sum  = {{18{mean_q[31]}}, mean_q} + {14'h0, pa_q[47:12]};
		thr      = abtd_pkg::sat32(thr_sum);
		abs_d    = d_q[32] ? (33'h0 - d_q) : d_q;
		var_sum  = {1'b0, var_q} + {1'b0, pb_q[63:16]};
		sq_shift = {rem_q, rad_q[63:62]};
		sq_trial = {2'b00, root_q, 2'b01};
		sq_diff  = sq_shift - sq_trial;
		sq_ge    = (sq_shift >= sq_trial);
		elapsed  = now_q - last_q;
		// The test runs on the updated mean and threshold of this word.
		beat       = !above_q && (y_q > thr) && (elapsed > {16'h0, cfg.holdoff_ms});
		above_set  = above_q || beat;
		above_next = above_set && !(y_q < mean_q);
	end

	always_ff @(posedge clk) begin
		pa_q <= ma_a * ma_b;
		pb_q <= mb_a * mb_b;
		if (take) begin
			x_q   <= q_x;
			now_q <= q_now;
		end
		case (state_q)
			abtd_pkg::ST_Y:   y_q <= abtd_pkg::sat32(y_sum);
			abtd_pkg::ST_MA1: d_q <= {y_q[31], y_q} - {mean_q[31], mean_q};
			abtd_pkg::ST_N1:  mag_q <= abs_d[32] ? 32'hFFFFFFFF : abs_d[31:0];
			abtd_pkg::ST_B2X: t_q <= {pa_q[31:0], 2'b00};
			abtd_pkg::ST_VSUM: sum_q <= var_sum[48] ? 48'hFFFFFFFFFFFF : var_sum[47:0];
			abtd_pkg::ST_VAR: begin
				rad_q  <= {pb_q[63:16], 16'h0};
				rem_q  <= '0;
				root_q <= '0;
				cnt_q  <= '0;
			end
			abtd_pkg::ST_SQRT: begin
				rad_q  <= {rad_q[61:0], 2'b00};
				rem_q  <= sq_ge ? sq_diff[33:0] : sq_shift[33:0];
				root_q <= {root_q[30:0], sq_ge};
				cnt_q  <= cnt_q + 5'd1;
			end
			default: ;
		endcase
		if (out_load) begin
			res_beat_q      <= beat;
			res_armed_q     <= above_next;
			res_filtered_q  <= y_q;
			res_threshold_q <= thr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= abtd_pkg::ST_IDLE;
			d1_q        <= '0;
			d2_q        <= '0;
			mean_q      <= '0;
			var_q       <= abtd_pkg::RST_VARIANCE;
			above_q     <= 1'b0;
			last_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				abtd_pkg::ST_N1:   d1_q   <= abtd_pkg::sat32(n1_sum);
				abtd_pkg::ST_N2:   d2_q   <= abtd_pkg::sat32(n2_sum);
				abtd_pkg::ST_MEAN: mean_q <= abtd_pkg::sat32(mean_sum);
				abtd_pkg::ST_VAR:  var_q  <= pb_q[63:16];
				default: ;
			endcase
			if (out_load) begin
				above_q <= above_next;
				if (beat) begin
					last_q <= now_q;
				end
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid     = res_valid_q;
	assign res_beat      = res_beat_q;
	assign res_armed     = res_armed_q;
	assign res_filtered  = res_filtered_q;
	assign res_threshold = res_threshold_q;

	a_load_from_thr: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> ($past(state_q) == abtd_pkg::ST_THR))
		else $error("result word appeared outside the threshold step");

	a_beat_arms: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_beat_q) |-> res_armed_q)
		else $error("beat word without armed flag");

	a_beat_above: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_beat_q) |-> (res_filtered_q > res_threshold_q))
		else $error("beat word with filter output not above threshold");

	a_sqrt_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == abtd_pkg::ST_GAIN) |-> ($past(state_q) == abtd_pkg::ST_SQRT &&
		$past(cnt_q) == 5'd31))
		else $error("square root left before all iterations");

endmodule

### verif/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the adaptive threshold beat detector core. Pulse
// trains and noise are streamed through the sample channel in random bursts
// while the result channel stalls on its own pattern. A bit-accurate
// predictor follows every accepted word, and the results are compared in
// order. Between phases the registers are rewritten over the APB port.
// ---------------------------------------------------------------------------
module testbench;

	localparam int SB = 10;

	typedef struct {
		logic [SB-1:0] smp;
		logic [31:0]   stamp;
	} sample_word_t;

	typedef struct {
		logic               beat;
		logic               armed;
		logic signed [31:0] filt;
		logic signed [31:0] thr;
	} beat_result_t;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic [SB-1:0] sample;
	logic [31:0] now_ms;
	logic beat, armed_high;
	logic signed [31:0] filtered, threshold;
	logic psel, penable, pwrite, pready;
	logic [4:0] paddr;
	logic [31:0] pwdata, prdata;

	adaptive_threshold_beat_detector_core #(.SAMPLE_BITS(SB)) dut (.*);

	sample_word_t pending_words[$];
	beat_result_t expected_beats[$];
	int mismatches = 0;

	// Predictor copy of the registers and the detector state.
	logic [15:0] m_b0, m_b2, m_a1, m_a2, m_rate, m_gain, m_refr;
	logic signed [31:0] m_d1, m_d2, m_mean;
	longint unsigned m_var;
	logic m_above;
	logic [31:0] m_last;

	function automatic logic signed [31:0] clip_s32(longint v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) r = 32'sh7FFFFFFF;
		else if (v < -64'sd2147483648) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction

	function automatic longint unsigned root_u64(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function beat_result_t predict_beat(logic [SB-1:0] smp, logic [31:0] stamp);
		longint x, b0, b2, a1, a2, rate, d;
		longint unsigned mag, term, sum, stdv, rate_u;
		logic signed [31:0] y, n1, n2, thr;
		logic [31:0] elapsed;
		beat_result_t r;
		x = longint'({1'b0, smp}) - (64'sd1 <<< (SB - 1));
		b0 = longint'($signed(m_b0));
		b2 = longint'($signed(m_b2));
		a1 = longint'($signed(m_a1));
		a2 = longint'($signed(m_a2));
		rate = longint'({1'b0, m_rate});
		rate_u = {48'd0, m_rate};
		y = clip_s32(4 * b0 * x + longint'(m_d1));
		n1 = clip_s32(longint'(m_d2) - ((a1 * longint'(y)) >>> 14));
		n2 = clip_s32(4 * b2 * x - ((a2 * longint'(y)) >>> 14));
		m_d1 = n1;
		m_d2 = n2;
		d = longint'(y) - longint'(m_mean);
		m_mean = clip_s32(longint'(m_mean) + ((rate * d) >>> 16));
		mag = (d < 0) ? longint'(-d) : longint'(d);
		if (mag > 64'hFFFFFFFF) mag = 64'hFFFFFFFF;
		term = (((mag * mag) >> 16) * rate_u) >> 16;
		sum = m_var + term;
		if (sum > 64'hFFFFFFFFFFFF) sum = 64'hFFFFFFFFFFFF;
		m_var = (sum * (64'd65536 - rate_u)) >> 16;
		stdv = root_u64(m_var << 16);
		if (stdv > 64'hFFFFFFFF) stdv = 64'hFFFFFFFF;
		thr = clip_s32(longint'(m_mean) + longint'(({48'd0, m_gain} * stdv) >> 12));
		elapsed = stamp - m_last;
		r.beat = 1'b0;
		if (!m_above && y > thr && elapsed > {16'd0, m_refr}) begin
			m_above = 1'b1;
			m_last = stamp;
			r.beat = 1'b1;
		end
		if (m_above && y < m_mean) m_above = 1'b0;
		r.armed = m_above;
		r.filt = y;
		r.thr = thr;
		return r;
	endfunction

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(12 * 3000000);
		$display("FAIL");
		$finish;
	end

	// Sender: bursts of words with random gaps between them.
	int burst_left, gap_left;
	always @(posedge clk or negedge arst_n) begin
		sample_word_t w;
		if (!arst_n) begin
			in_valid <= 1'b0;
			sample <= '0;
			now_ms <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (in_valid && !in_stall) expected_beats.push_back(predict_beat(sample, now_ms));
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (pending_words.size() > 0) begin
					w = pending_words.pop_front();
					in_valid <= 1'b1;
					sample <= w.smp;
					now_ms <= w.stamp;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 70);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: stalls in one of four modes, drawn anew when its hold counter runs out.
	int stall_mode, stall_count, cyc;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_mode <= 0;
			stall_count <= 0;
			cyc <= 0;
		end else begin
			cyc <= cyc + 1;
			if (stall_count == 0) begin
				stall_mode <= $urandom_range(0, 3);
				stall_count <= $urandom_range(50, 500);
			end else begin
				stall_count <= stall_count - 1;
			end
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 2) == 0);
				2: out_stall <= ((cyc % 97) < 70);
				default: out_stall <= ($urandom_range(0, 9) < 8);
			endcase
		end
	end

	// Result checker.
	always @(posedge clk) begin
		beat_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_beats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result word");
			end else begin
				e = expected_beats.pop_front();
				if (beat !== e.beat || armed_high !== e.armed ||
						filtered !== e.filt || threshold !== e.thr) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp beat=%0d armed=%0d filt=%0d thr=%0d, got %0d %0d %0d %0d",
							e.beat, e.armed, e.filt, e.thr, beat, armed_high, filtered, threshold);
				end
			end
		end
	end

	task automatic reg_write(input int idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= 5'(idx * 4);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			abtd_pkg::RI_COEF_B0:     m_b0 = value[15:0];
			abtd_pkg::RI_COEF_B2:     m_b2 = value[15:0];
			abtd_pkg::RI_COEF_A1:     m_a1 = value[15:0];
			abtd_pkg::RI_COEF_A2:     m_a2 = value[15:0];
			abtd_pkg::RI_STATS_RATE:  m_rate = value[15:0];
			abtd_pkg::RI_THRESH_GAIN: m_gain = value[15:0];
			abtd_pkg::RI_HOLDOFF_MS:  m_refr = value[15:0];
			default: ;
		endcase
	endtask

	task automatic load_config(input logic [15:0] b0, b2, a1, a2, rate, gain, refr);
		reg_write(abtd_pkg::RI_COEF_B0, {16'($urandom_range(0, 65535)), b0});
		reg_write(abtd_pkg::RI_COEF_B2, {16'($urandom_range(0, 65535)), b2});
		reg_write(abtd_pkg::RI_COEF_A1, {16'($urandom_range(0, 65535)), a1});
		reg_write(abtd_pkg::RI_COEF_A2, {16'($urandom_range(0, 65535)), a2});
		reg_write(abtd_pkg::RI_STATS_RATE, {16'd0, rate});
		reg_write(abtd_pkg::RI_THRESH_GAIN, {16'd0, gain});
		reg_write(abtd_pkg::RI_HOLDOFF_MS, {16'd0, refr});
		// Index seven is not a register and must leave everything alone.
		reg_write(7, $urandom);
	endtask

	task automatic push_word(input logic [SB-1:0] smp, input logic [31:0] stamp);
		sample_word_t w;
		w.smp = smp;
		w.stamp = stamp;
		pending_words.push_back(w);
	endtask

	logic [31:0] clock_ms;

	// Pulse-like waveform: a sharp rise and slow decay once per period, plus noise.
	task automatic pulse_train(input int count);
		int period, amp, step, pos, v;
		period = $urandom_range(20, 60);
		amp = $urandom_range(20, 511);
		step = $urandom_range(5, 40);
		for (int i = 0; i < count; i++) begin
			pos = i % period;
			if (pos < 3) v = 512 + (amp * pos) / 3;
			else v = 512 + amp - (amp * (pos - 3)) / (period - 3) * 3 / 2;
			v = v + $urandom_range(0, 16) - 8;
			if ($urandom_range(0, 30) == 0) v = $urandom_range(0, 1023);
			if (v < 0) v = 0;
			if (v > 1023) v = 1023;
			clock_ms = clock_ms + step;
			if ($urandom_range(0, 60) == 0) clock_ms = $urandom;
			push_word(v[SB-1:0], clock_ms);
		end
	endtask

	task automatic drain;
		while (pending_words.size() > 0 || in_valid || expected_beats.size() > 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		m_b0 = abtd_pkg::RST_COEF_B0;
		m_b2 = abtd_pkg::RST_COEF_B2;
		m_a1 = abtd_pkg::RST_COEF_A1;
		m_a2 = abtd_pkg::RST_COEF_A2;
		m_rate = abtd_pkg::RST_STATS_RATE;
		m_gain = abtd_pkg::RST_THRESH_GAIN;
		m_refr = abtd_pkg::RST_HOLDOFF_MS;
		m_d1 = 0; m_d2 = 0; m_mean = 0; m_var = abtd_pkg::RST_VARIANCE;
		m_above = 1'b0; m_last = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: field extremes, then a beat across the timestamp wrap.
		push_word('0, 32'd0);
		push_word('1, 32'd1);
		push_word(10'd512, 32'hFFFFFFFF);
		push_word(10'd511, 32'h80000000);
		push_word(10'd513, 32'h7FFFFFFF);
		push_word('1, 32'hFFFFFF00);
		for (int i = 0; i < 8; i++) push_word(10'd512, 32'hFFFFFF00 + 32'(i * 40));
		for (int i = 0; i < 6; i++) push_word(i[0] ? 10'd1023 : 10'd0, 32'(i * 100));
		for (int i = 0; i < 5; i++) push_word(10'd1023, 32'(900 + i * 5));
		clock_ms = 32'd1000;
		pulse_train(300);
		drain();

		// Saturating coefficients at the positive extremes, zero refractory.
		load_config(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'd0);
		pulse_train(200);
		drain();

		// Negative extremes and frozen statistics.
		load_config(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'd0, 16'd0, 16'hFFFF);
		pulse_train(200);
		drain();

		// Back to a sane band-pass with a small rate.
		load_config(abtd_pkg::RST_COEF_B0, abtd_pkg::RST_COEF_B2, abtd_pkg::RST_COEF_A1,
			abtd_pkg::RST_COEF_A2, 16'd1, 16'd4096, 16'd100);
		pulse_train(250);
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			load_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom), 16'($urandom), 16'($urandom_range(0, 600)));
			pulse_train(150);
			drain();
		end

		load_config(abtd_pkg::RST_COEF_B0, abtd_pkg::RST_COEF_B2, abtd_pkg::RST_COEF_A1,
			abtd_pkg::RST_COEF_A2, abtd_pkg::RST_STATS_RATE, abtd_pkg::RST_THRESH_GAIN,
			abtd_pkg::RST_HOLDOFF_MS);
		pulse_train(400);
		drain();

		if (mismatches == 0 && expected_beats.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
